// File: rtl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
// No dependencies; used by wpm_cell and wildcard_pattern_match.
`default_nettype none

package wpm_pkg;

  // Default pattern store depth.
  localparam int PatternMaxDef = 64;

  // Pattern symbols with special meaning.
  localparam logic [7:0] SymStar = 8'd42;  // any run, empty included
  localparam logic [7:0] SymAny  = 8'd63;  // any single character

  // Input word kinds. Code 3 is unused and handled by default arms.
  typedef enum logic [1:0] {
    ModeClear  = 2'd0,
    ModeAppend = 2'd1,
    ModeText   = 2'd2
  } mode_e;

  // Control sequencer states.
  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StRun    = 2'd1,
    StReport = 2'd2
  } state_e;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic       clr;      // drop all match bits
    logic       wr;       // append a symbol at the cell at the current length
    logic [7:0] sym;      // symbol to append
    logic       wr_bit;   // match bit of the appended prefix
  } wpm_ctrl_t;

  // Cell to cell link, registered in the sending cell.
  typedef struct packed {
    logic       tok;      // wavefront of a text character
    logic       new_b;    // updated match bit of the sending prefix
    logic       old_b;    // match bit of the sending prefix before the update
    logic [7:0] chr;      // text character
  } wpm_link_t;

  // Tap from a cell back to the control.
  typedef struct packed {
    logic hit;            // this cell is the last pattern symbol and just updated
    logic bit_v;          // its new match bit
  } wpm_tap_t;

endpackage

`default_nettype wire

// File: rtl/wpm_cell.sv
// One cell of the matcher chain: a pattern symbol and the match bit of its prefix.
// Depends on wpm_pkg.
`default_nettype none

module wpm_cell #(
  parameter int CellIdx = 0,
  parameter int LenW    = 7
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wpm_pkg::wpm_ctrl_t  ctrl_i,
  input  wire [LenW-1:0]      len_i,
  input  wpm_pkg::wpm_link_t  link_i,
  output wpm_pkg::wpm_link_t  link_o,
  output wpm_pkg::wpm_tap_t   tap_o
);

  logic [7:0]         sym_q;
  logic               bit_q, bit_d;
  logic               proc;
  logic               nb;
  logic               wr_here;
  wpm_pkg::wpm_link_t link_q, link_d;

  // Cell takes part only when it lies inside the loaded pattern.
  assign proc    = link_i.tok & (LenW'(CellIdx) < len_i);
  assign wr_here = ctrl_i.wr & (len_i == LenW'(CellIdx));

  // Recurrence for one prefix
  always_comb begin
    if (sym_q == wpm_pkg::SymAny) begin
      nb = link_i.old_b;
    end else if (sym_q == wpm_pkg::SymStar) begin
      nb = link_i.new_b | bit_q;
    end else begin
      nb = (sym_q == link_i.chr) & link_i.old_b;
    end
  end

  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.clr) begin
      bit_d = 1'b0;
    end else if (wr_here) begin
      bit_d = ctrl_i.wr_bit;
    end else if (proc) begin
      bit_d = nb;
    end
  end

  // Carry to the next cell; the wavefront stops past the pattern end.
  always_comb begin
    link_d.tok   = proc;
    link_d.new_b = nb;
    link_d.old_b = bit_q;
    link_d.chr   = link_i.chr;
  end

  // Symbol store, no reset
  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      sym_q <= ctrl_i.sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= 1'b0;
      link_q <= '0;
    end else begin
      bit_q  <= bit_d;
      link_q <= link_d;
    end
  end

  assign link_o      = link_q;
  assign tap_o.hit   = proc & (LenW'(CellIdx + 1) == len_i);
  assign tap_o.bit_v = nb;

endmodule

`default_nettype wire

// File: rtl/wildcard_pattern_match.sv
// Wildcard matcher top level: control sequencer, output register, cell chain.
// Depends on wpm_pkg and wpm_cell.
//
// Usage: one input channel (in_valid_i / in_stall_o, fields mode_i, symbol_i)
// and one result channel (out_valid_o / out_stall_i, fields matched_o,
// error_o). Every input word gives exactly one result word. Mode clear
// empties pattern and text, mode append adds a pattern symbol ('*' any run,
// '?' any character), mode text feeds one text character.
// Flow: a text character travels down the cell chain one cell per cycle;
// the match bit of the last pattern cell is registered and then loaded
// into the output register. Clear, append, the unused mode and text on an
// empty pattern go straight to reporting. The chain holds one word at a
// time; the next word is taken the cycle after its result is loaded.
// The output register decouples the sides: a new word is taken while a
// finished result waits on a stalled receiver; the following result waits
// for the register to free up. Reset empties pattern and text, leaves the
// output register empty and takes effect at once; no clearing pass.
`default_nettype none

module wildcard_pattern_match #(
  parameter int PatternMax = wpm_pkg::PatternMaxDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [1:0]  mode_i,
  input  wire [7:0]  symbol_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic       matched_o,
  output logic       error_o
);

  localparam int LenW = $clog2(PatternMax + 1);

  wpm_pkg::state_e    state_q, state_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic               started_q, started_d;
  logic               row0_q, row0_d;
  logic               last_q, last_d;
  logic               err_q;
  logic               out_valid_q;
  logic               out_matched_q;
  logic               out_error_q;
  wpm_pkg::wpm_link_t inj_q, inj_d;
  wpm_pkg::wpm_ctrl_t ctrl;

  logic accept, load;
  logic do_clr, do_app, do_text;
  logic app_err, app_ok;

  wpm_pkg::wpm_link_t links [PatternMax+1];
  wpm_pkg::wpm_tap_t  taps  [PatternMax];
  logic [PatternMax-1:0] hit_vec, hitbit_vec, tok_vec;

  // Word decode
  assign accept = in_valid_i & (state_q == wpm_pkg::StIdle);

  always_comb begin
    do_clr  = 1'b0;
    do_app  = 1'b0;
    do_text = 1'b0;
    unique case (wpm_pkg::mode_e'(mode_i))
      wpm_pkg::ModeClear:  do_clr  = accept;
      wpm_pkg::ModeAppend: do_app  = accept;
      wpm_pkg::ModeText:   do_text = accept;
      default: ;
    endcase
  end

  assign app_err = do_app & (started_q | (len_q == LenW'(PatternMax)));
  assign app_ok  = do_app & ~app_err;

  // Broadcast to the cells
  always_comb begin
    ctrl.clr    = do_clr;
    ctrl.wr     = app_ok;
    ctrl.sym    = symbol_i;
    ctrl.wr_bit = (symbol_i == wpm_pkg::SymStar) & last_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wpm_pkg::StIdle: begin
        if (accept) begin
          state_d = (do_text && (len_q != '0)) ? wpm_pkg::StRun : wpm_pkg::StReport;
        end
      end
      wpm_pkg::StRun: begin
        if (rem_q == LenW'(1)) state_d = wpm_pkg::StReport;
      end
      wpm_pkg::StReport: begin
        if (load) state_d = wpm_pkg::StIdle;
      end
      default: state_d = wpm_pkg::StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    load       = 1'b0;
    unique case (state_q)
      wpm_pkg::StIdle:   in_stall_o = 1'b0;
      wpm_pkg::StRun:    ;
      wpm_pkg::StReport: load = ~out_valid_q | ~out_stall_i;
      default: ;
    endcase
  end

  // Pattern and row bookkeeping
  always_comb begin
    len_d     = len_q;
    started_d = started_q;
    row0_d    = row0_q;
    last_d    = last_q;
    rem_d     = rem_q;
    if (do_clr) begin
      len_d     = '0;
      started_d = 1'b0;
      row0_d    = 1'b1;
      last_d    = 1'b1;
    end else if (app_ok) begin
      len_d  = len_q + LenW'(1);
      last_d = ctrl.wr_bit;
    end else if (do_text) begin
      started_d = 1'b1;
      row0_d    = 1'b0;
      rem_d     = len_q;
      if (len_q == '0) last_d = 1'b0;
    end else begin
      if (state_q == wpm_pkg::StRun) rem_d = rem_q - LenW'(1);
      if (|hit_vec) last_d = |(hit_vec & hitbit_vec);
    end
  end

  // Wavefront injection into the first cell
  always_comb begin
    inj_d.tok   = do_text;
    inj_d.new_b = 1'b0;
    inj_d.old_b = row0_q;
    inj_d.chr   = symbol_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wpm_pkg::StIdle;
      len_q     <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
      row0_q    <= 1'b1;
      last_q    <= 1'b1;
      inj_q     <= '0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
      started_q <= started_d;
      row0_q    <= row0_d;
      last_q    <= last_d;
      inj_q     <= inj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) err_q <= app_err;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_matched_q <= last_q;
      out_error_q   <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = out_matched_q;
  assign error_o     = out_error_q;

  // Cell chain
  assign links[0] = inj_q;

  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    wpm_cell #(
      .CellIdx (k),
      .LenW    (LenW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .len_i  (len_q),
      .link_i (links[k]),
      .link_o (links[k+1]),
      .tap_o  (taps[k])
    );
    assign hit_vec[k]    = taps[k].hit;
    assign hitbit_vec[k] = taps[k].bit_v;
    assign tok_vec[k]    = links[k].tok;
  end

  // Checks
  a_one_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vec) <= 1)
    else $error("more than one wavefront in the chain");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(PatternMax))
    else $error("pattern length beyond store depth");

  a_run_has_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wpm_pkg::StRun) |-> (|tok_vec))
    else $error("sweep without a wavefront");

  a_load_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == wpm_pkg::StReport))
    else $error("result loaded outside report state");

  a_late_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_app && started_q) |=> (err_q && $stable(len_q)))
    else $error("append after text not flagged");

endmodule

`default_nettype wire
